FILE: rtl/pli_pkg.sv
package pli_pkg;

	// table geometry
	localparam int MAX_POINTS = 32;
	localparam int PT_IDX_W   = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int DATA_W     = 32;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;
	localparam logic [CFG_IDX_W-1:0] REG_POINTS_IN_USE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_ON_RANGE = 1'b1;
	localparam logic [CNT_W-1:0]     POINTS_RESET       = CNT_W'(2);

	// request function codes
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_EVAL  = 1'b1;

	// divider: quotient bits left once saturation is ruled out
	localparam int DIV_STEPS = DATA_W - 1;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RANGE,
		ST_CHECK,
		ST_SCAN,
		ST_END_Y,
		ST_MUL_A,
		ST_MUL_B,
		ST_SUM,
		ST_ABS,
		ST_PREP,
		ST_DIV,
		ST_QUOT,
		ST_DONE
	} pli_state_t;

	// controller to datapath
	typedef struct packed {
		logic                wr_pt;
		logic                ld_v;
		logic                rd_en;
		logic [PT_IDX_W-1:0] rd_a;
		logic [PT_IDX_W-1:0] rd_b;
		logic                mul_a;
		logic                mul_b;
		logic                sum;
		logic                absv;
		logic                prep;
		logic                div_step;
		logic                ld_res_zero;
		logic                ld_res_y;
		logic                ld_res_quot;
		logic                ld_out;
	} pli_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic below;
		logic above;
		logic hit;
		logic sat;
	} pli_sts_t;

endpackage

FILE: rtl/pli_if.sv
// request channel
interface pli_item_if;
	import pli_pkg::*;
	logic                valid;
	logic                ready;
	logic                func;
	logic [PT_IDX_W-1:0] point_index;
	logic signed [31:0]  point_x;
	logic signed [31:0]  point_y;
	logic signed [31:0]  sample_value;

	modport source (output valid, func, point_index, point_x, point_y, sample_value,
		input ready);
	modport sink (input valid, func, point_index, point_x, point_y, sample_value,
		output ready);
endinterface

// result channel
interface pli_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result_value;
	logic               out_of_range;

	modport source (output valid, result_value, out_of_range, input ready);
	modport sink (input valid, result_value, out_of_range, output ready);
endinterface

// configuration write channel
interface pli_cfg_if;
	import pli_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/pli_ctrl.sv
module pli_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_func,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  logic               cfg_valid,
	input  logic [pli_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pli_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic               cfg_ready,
	output pli_pkg::pli_cmd_t  cmd,
	input  pli_pkg::pli_sts_t  sts
);
	import pli_pkg::*;

	pli_state_t            state_q, state_d;
	logic [CNT_W-1:0]      points_q;
	logic                  err_mode_q;
	logic [PT_IDX_W-1:0]   k_q;
	logic                  tst_q;
	logic [DIV_CNT_W-1:0]  div_cnt_q;
	logic                  out_valid_q;
	logic [PT_IDX_W-1:0]   last_idx;
	logic                  accept;
	logic                  seg_hit;
	logic                  all_issued;
	logic                  out_free;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// index of the last live breakpoint, count clamped to 2..MAX_POINTS
	always_comb begin
		priority if (points_q < CNT_W'(2)) begin
			last_idx = PT_IDX_W'(1);
		end else if (points_q > CNT_W'(MAX_POINTS)) begin
			last_idx = PT_IDX_W'(MAX_POINTS - 1);
		end else begin
			last_idx = PT_IDX_W'(points_q - CNT_W'(1));
		end
	end

	assign seg_hit    = tst_q && sts.hit;
	assign all_issued = (k_q == last_idx);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && in_func == FUNC_EVAL) state_d = ST_RANGE;
			end
			ST_RANGE: state_d = ST_CHECK;
			ST_CHECK: begin
				if (sts.below || sts.above) begin
					state_d = err_mode_q ? ST_DONE : ST_END_Y;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				priority if (seg_hit) state_d = ST_MUL_A;
				else if (all_issued) state_d = ST_END_Y;
				else state_d = ST_SCAN;
			end
			ST_END_Y: state_d = ST_DONE;
			ST_MUL_A: state_d = ST_MUL_B;
			ST_MUL_B: state_d = ST_SUM;
			ST_SUM:   state_d = ST_ABS;
			ST_ABS:   state_d = ST_PREP;
			ST_PREP:  state_d = ST_DIV;
			ST_DIV: begin
				if (sts.sat || div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) state_d = ST_QUOT;
			end
			ST_QUOT: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.wr_pt = accept && in_func == FUNC_WRITE;
				cmd.ld_v  = accept && in_func == FUNC_EVAL;
			end
			ST_RANGE: begin
				cmd.rd_en = 1'b1;
				cmd.rd_a  = '0;
				cmd.rd_b  = last_idx;
			end
			ST_CHECK: begin
				if (sts.below || sts.above) begin
					cmd.ld_res_zero = err_mode_q;
					cmd.rd_en       = !err_mode_q;
					cmd.rd_a        = sts.below ? '0 : last_idx;
					cmd.rd_b        = last_idx;
				end
			end
			ST_SCAN: begin
				priority if (seg_hit) begin
					cmd.rd_en = 1'b0;
				end else if (all_issued) begin
					// no segment holds the sample: fall back to the last ordinate
					cmd.rd_en = 1'b1;
					cmd.rd_a  = last_idx;
					cmd.rd_b  = last_idx;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.rd_a  = k_q;
					cmd.rd_b  = k_q + PT_IDX_W'(1);
				end
			end
			ST_END_Y: cmd.ld_res_y = 1'b1;
			ST_MUL_A: cmd.mul_a    = 1'b1;
			ST_MUL_B: cmd.mul_b    = 1'b1;
			ST_SUM:   cmd.sum      = 1'b1;
			ST_ABS:   cmd.absv     = 1'b1;
			ST_PREP:  cmd.prep     = 1'b1;
			ST_DIV:   cmd.div_step = !sts.sat;
			ST_QUOT:  cmd.ld_res_quot = 1'b1;
			ST_DONE:  cmd.ld_out   = out_free;
			default:  cmd = '0;
		endcase
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			k_q       <= '0;
			tst_q     <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			tst_q   <= (state_q == ST_SCAN) && !seg_hit && !all_issued;
			if (state_q == ST_CHECK) begin
				k_q <= '0;
			end else if (state_q == ST_SCAN && !seg_hit && !all_issued) begin
				k_q <= k_q + PT_IDX_W'(1);
			end
			if (state_q == ST_PREP) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end
		end
	end

	// result slot occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.ld_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_q   <= POINTS_RESET;
			err_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_POINTS_IN_USE:  points_q   <= cfg_data;
				REG_ERROR_ON_RANGE: err_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

FILE: rtl/pli_dp.sv
module pli_dp (
	input  logic                clk,
	input  logic [pli_pkg::PT_IDX_W-1:0] point_index,
	input  logic signed [31:0]  point_x,
	input  logic signed [31:0]  point_y,
	input  logic signed [31:0]  sample_value,
	input  pli_pkg::pli_cmd_t   cmd,
	output pli_pkg::pli_sts_t   sts,
	output logic signed [31:0]  result_value,
	output logic                out_of_range
);
	import pli_pkg::*;

	logic [DATA_W-1:0]   mem_x [MAX_POINTS];
	logic [DATA_W-1:0]   mem_y [MAX_POINTS];
	logic [DATA_W-1:0]   xa_q, xb_q, ya_q, yb_q;
	logic [DATA_W-1:0]   v_q;
	logic signed [32:0]  d0, d1;
	logic signed [31:0]  op_y;
	logic signed [32:0]  op_d;
	logic signed [64:0]  prod;
	logic signed [64:0]  p1_q, p2_q;
	logic signed [64:0]  psum;
	logic [63:0]         num_q;
	logic [63:0]         mag_q;
	logic                neg_q;
	logic                sat_q;
	logic [DATA_W-1:0]   span;
	logic [DATA_W-1:0]   rem_q;
	logic [DIV_STEPS-1:0] quo_q;
	logic [DATA_W:0]     trial;
	logic                trial_ge;
	logic [DATA_W:0]     trial_sub;
	logic [DATA_W-1:0]   q_ext;
	logic [DATA_W-1:0]   q_val;
	logic [DATA_W-1:0]   res_q;
	logic                flag_q;
	logic [DATA_W-1:0]   out_val_q;
	logic                out_flag_q;

	// breakpoint tables, one write and two read ports each
	always_ff @(posedge clk) begin
		if (cmd.wr_pt) begin
			mem_x[point_index] <= point_x;
			mem_y[point_index] <= point_y;
		end
		if (cmd.rd_en) begin
			xa_q <= mem_x[cmd.rd_a];
			xb_q <= mem_x[cmd.rd_b];
			ya_q <= mem_y[cmd.rd_a];
			yb_q <= mem_y[cmd.rd_b];
		end
	end

	// sample latch
	always_ff @(posedge clk) begin
		if (cmd.ld_v) v_q <= sample_value;
	end

	// range and segment compares
	assign sts.below = $signed(v_q) < $signed(xa_q);
	assign sts.above = $signed(v_q) > $signed(xb_q);
	assign sts.hit   = ($signed(xa_q) <= $signed(v_q)) && ($signed(v_q) < $signed(xb_q));
	assign sts.sat   = sat_q;

	// distances to both ends of the segment, one shared multiplier
	assign d0   = $signed({v_q[31], v_q}) - $signed({xa_q[31], xa_q});
	assign d1   = $signed({xb_q[31], xb_q}) - $signed({v_q[31], v_q});
	assign op_y = cmd.mul_b ? $signed(ya_q) : $signed(yb_q);
	assign op_d = cmd.mul_b ? d1 : d0;
	assign prod = op_y * op_d;
	assign psum = p1_q + p2_q;
	assign span = xb_q - xa_q;

	always_ff @(posedge clk) begin
		if (cmd.mul_a) p1_q <= prod;
		if (cmd.mul_b) p2_q <= prod;
		if (cmd.sum)   num_q <= psum[63:0];
		if (cmd.absv) begin
			neg_q <= num_q[63];
			mag_q <= num_q[63] ? (~num_q + 64'd1) : num_q;
		end
	end

	// restoring divider, one quotient bit a cycle
	assign trial     = {rem_q, quo_q[DIV_STEPS-1]};
	assign trial_ge  = trial >= {1'b0, span};
	assign trial_sub = trial - {1'b0, span};

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			sat_q <= mag_q >= {1'b0, span, {DIV_STEPS{1'b0}}};
			rem_q <= mag_q[62:DIV_STEPS];
			quo_q <= mag_q[DIV_STEPS-1:0];
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? trial_sub[DATA_W-1:0] : trial[DATA_W-1:0];
			quo_q <= {quo_q[DIV_STEPS-2:0], trial_ge};
		end
	end

	// signed, saturated quotient
	assign q_ext = {1'b0, quo_q};
	always_comb begin
		priority if (sat_q) begin
			q_val = neg_q ? SAT_MIN : SAT_MAX;
		end else if (neg_q) begin
			q_val = ~q_ext + DATA_W'(1);
		end else begin
			q_val = q_ext;
		end
	end

	// result and output registers
	always_ff @(posedge clk) begin
		if (cmd.ld_res_zero) begin
			res_q  <= '0;
			flag_q <= 1'b1;
		end else if (cmd.ld_res_y) begin
			res_q  <= ya_q;
			flag_q <= 1'b0;
		end else if (cmd.ld_res_quot) begin
			res_q  <= q_val;
			flag_q <= 1'b0;
		end
		if (cmd.ld_out) begin
			out_val_q  <= res_q;
			out_flag_q <= flag_q;
		end
	end

	assign result_value = out_val_q;
	assign out_of_range = out_flag_q;

endmodule

FILE: rtl/piecewise_linear_interpolator.sv
// Piecewise linear interpolator over a table of up to 32 signed Q16.16
// breakpoints. A request with func 0 writes one point (no result); a request
// with func 1 evaluates a sample and gives one result. The table must hold
// strictly ascending x values and every entry up to points_in_use must be
// written before evaluating. Inside the table, an evaluation walks the
// table one breakpoint a cycle through the two-port table memories in a
// segment search, followed by two passes of one shared multiplier and a
// restoring divider giving one quotient bit a cycle (skipped when the
// quotient saturates). A finished result waits in an output register, so
// the next request is taken meanwhile.
module piecewise_linear_interpolator (
	input  logic         clk,
	input  logic         arst_n,
	pli_item_if.sink     sample,
	pli_result_if.source result,
	pli_cfg_if.sink      cfg
);
	import pli_pkg::*;

	pli_cmd_t cmd;
	pli_sts_t sts;

	// controller
	pli_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_func   (sample.func),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cfg_valid (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.cfg_ready (cfg.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// datapath
	pli_dp u_dp (
		.clk          (clk),
		.point_index  (sample.point_index),
		.point_x      (sample.point_x),
		.point_y      (sample.point_y),
		.sample_value (sample.sample_value),
		.cmd          (cmd),
		.sts          (sts),
		.result_value (result.result_value),
		.out_of_range (result.out_of_range)
	);

endmodule

FILE: sim/tb_piecewise_linear_interpolator.sv
`timescale 1ns / 100ps

module tb_piecewise_linear_interpolator;
	import pli_pkg::*;

	typedef logic signed [DATA_W-1:0] q16_t;

	typedef struct {
		logic                func;
		logic [PT_IDX_W-1:0] point_index;
		q16_t                point_x;
		q16_t                point_y;
		q16_t                sample_value;
	} request_t;

	typedef struct {
		q16_t result_value;
		logic out_of_range;
	} outcome_t;

	localparam longint Q_MIN    = -64'sd2147483648;
	localparam longint Q_MAX    = 64'sd2147483647;
	localparam longint SPAN_ALL = 64'sd4294967295;
	localparam int     PHASES   = 12;
	localparam int     PHASE_ITEMS = 60;
	localparam int     DRAIN_CYCLES = 100;

	// breakpoint layouts for a table fill
	localparam int SHAPE_WIDE      = 0;
	localparam int SHAPE_NARROW    = 1;
	localparam int SHAPE_TINY      = 2;
	localparam int SHAPE_SCRAMBLED = 3;

	logic clk;
	logic arst_n;

	pli_item_if   sample_if ();
	pli_result_if result_if ();
	pli_cfg_if    cfg_if ();

	piecewise_linear_interpolator u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_if),
		.result (result_if),
		.cfg    (cfg_if)
	);

	// mirror of the block's table and registers, the table updated as requests are taken
	q16_t                  table_x [MAX_POINTS];
	q16_t                  table_y [MAX_POINTS];
	logic [CFG_DATA_W-1:0] points_reg = CFG_DATA_W'(POINTS_RESET);
	logic                  error_mode = 1'b0;

	// abscissae as the stimulus side last wrote them
	q16_t plan_x [MAX_POINTS];

	request_t request_queue [$];
	outcome_t expected_results [$];
	request_t offered;
	outcome_t oldest_expected;
	int       mismatch_count = 0;
	int       send_idle_pct = 0;
	int       recv_idle_pct = 0;
	int       count_plan [6] = '{2, 32, 0, 63, 1, 33};

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#5000000;
		$display("== FAIL ==");
		$finish;
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 200)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	function automatic int live_points(input logic [CFG_DATA_W-1:0] n);
		if (n < 2)
			return 2;
		if (n > MAX_POINTS)
			return MAX_POINTS;
		return int'(n);
	endfunction

	// expected outcome of one evaluation against the mirrored table
	function automatic outcome_t interpolate_sample(input q16_t v);
		outcome_t o;
		int       n;
		longint   first_x, last_x, x0, x1, y0, y1, num, quot;
		n = live_points(points_reg);
		first_x = table_x[0];
		last_x = table_x[n-1];
		o.out_of_range = 1'b0;
		o.result_value = '0;
		// outside the table: flag or clamp to the nearer end
		if (v < first_x || v > last_x) begin
			if (error_mode) begin
				o.out_of_range = 1'b1;
			end else begin
				o.result_value = (v < first_x) ? table_y[0] : table_y[n-1];
			end
			return o;
		end
		// first segment with x0 <= v < x1
		for (int i = 0; i + 1 < n; i++) begin
			x0 = table_x[i];
			x1 = table_x[i+1];
			if (x0 <= v && v < x1) begin
				y0 = table_y[i];
				y1 = table_y[i+1];
				num = y1 * (v - x0) + y0 * (x1 - v);
				quot = num / (x1 - x0);
				if (quot > Q_MAX)
					quot = Q_MAX;
				if (quot < Q_MIN)
					quot = Q_MIN;
				o.result_value = q16_t'(quot);
				return o;
			end
		end
		// last breakpoint itself, or no segment holds the sample
		o.result_value = table_y[n-1];
		return o;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_if.valid <= 1'b0;
		end else begin
			// request taken: update the table or predict the result
			if (sample_if.valid && sample_if.ready) begin
				if (offered.func == FUNC_WRITE) begin
					table_x[offered.point_index] = offered.point_x;
					table_y[offered.point_index] = offered.point_y;
				end else begin
					expected_results.push_back(interpolate_sample(offered.sample_value));
				end
			end
			// offer the next request unless the sender idles
			if (!sample_if.valid || sample_if.ready) begin
				if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					offered = request_queue.pop_front();
					sample_if.valid        <= 1'b1;
					sample_if.func         <= offered.func;
					sample_if.point_index  <= offered.point_index;
					sample_if.point_x      <= offered.point_x;
					sample_if.point_y      <= offered.point_y;
					sample_if.sample_value <= offered.sample_value;
				end else begin
					sample_if.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
		end else begin
			if (result_if.valid && result_if.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result %h with nothing outstanding",
						result_if.result_value));
				end else begin
					oldest_expected = expected_results.pop_front();
					if (result_if.result_value !== oldest_expected.result_value)
						report_mismatch($sformatf("result_value %h, expected %h",
							result_if.result_value, oldest_expected.result_value));
					if (result_if.out_of_range !== oldest_expected.out_of_range)
						report_mismatch($sformatf("out_of_range %b, expected %b",
							result_if.out_of_range, oldest_expected.out_of_range));
				end
			end
			result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic queue_write(input int idx, input q16_t x, input q16_t y);
		request_t r;
		r.func = FUNC_WRITE;
		r.point_index = PT_IDX_W'(idx);
		r.point_x = x;
		r.point_y = y;
		r.sample_value = $urandom;
		request_queue.push_back(r);
		plan_x[idx] = x;
	endtask

	task automatic queue_eval(input q16_t v);
		request_t r;
		r.func = FUNC_EVAL;
		r.point_index = PT_IDX_W'($urandom);
		r.point_x = $urandom;
		r.point_y = $urandom;
		r.sample_value = v;
		request_queue.push_back(r);
	endtask

	// all requests taken, all results in, then a margin for a trailing write
	task automatic wait_idle();
		while (request_queue.size() != 0 || sample_if.valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		if (idx == REG_POINTS_IN_USE)
			points_reg = value;
		else
			error_mode = value[0];
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] points, input logic err);
		wait_idle();
		write_register(REG_POINTS_IN_USE, points);
		write_register(REG_ERROR_ON_RANGE, CFG_DATA_W'(err));
	endtask

	function automatic q16_t random_ordinate();
		if ($urandom_range(1))
			return $urandom;
		// within +-64.0
		return q16_t'(longint'($urandom_range(0, 32'd8388608)) - 64'sd4194304);
	endfunction

	// write points 0..n-1 with the given layout
	task automatic fill_table(input int n, input int shape);
		q16_t   xs [MAX_POINTS];
		longint steps [MAX_POINTS];
		longint step_max, spent, acc;
		case (shape)
			SHAPE_WIDE:   step_max = SPAN_ALL / (n - 1);
			SHAPE_NARROW: step_max = 64'sd262144;
			default:      step_max = 64'sd3;
		endcase
		spent = 0;
		for (int i = 1; i < n; i++) begin
			steps[i] = 1 + longint'($urandom_range(0, 32'(step_max - 1)));
			spent += steps[i];
		end
		if (shape == SHAPE_WIDE)
			acc = Q_MIN + longint'($urandom_range(0, 32'(SPAN_ALL - spent)));
		else
			acc = longint'($urandom_range(0, 32'd2097152)) - 64'sd1048576;
		xs[0] = q16_t'(acc);
		for (int i = 1; i < n; i++) begin
			acc += steps[i];
			xs[i] = q16_t'(acc);
		end
		// unordered abscissae
		if (shape == SHAPE_SCRAMBLED)
			for (int i = 0; i < n; i++)
				xs[i] = $urandom;
		// order of the writes does not matter to the block
		if ($urandom_range(1)) begin
			for (int i = 0; i < n; i++)
				queue_write(i, xs[i], random_ordinate());
		end else begin
			for (int i = n - 1; i >= 0; i--)
				queue_write(i, xs[i], random_ordinate());
		end
	endtask

	// sample aimed at a segment, a breakpoint or either side of the table
	function automatic q16_t pick_sample(input int n);
		longint first, last, lo, hi, gap;
		int     i, pick;
		first = plan_x[0];
		last = plan_x[n-1];
		pick = $urandom_range(99);
		if (pick < 50) begin
			i = $urandom_range(0, n - 2);
			lo = plan_x[i];
			hi = plan_x[i+1];
			if (hi > lo)
				return q16_t'(lo + longint'($urandom_range(0, 32'(hi - lo - 1))));
		end else if (pick < 62) begin
			return plan_x[$urandom_range(0, n - 1)];
		end else if (pick < 68) begin
			return plan_x[n-1];
		end else if (pick < 78) begin
			gap = first - Q_MIN;
			if (gap > 0)
				return q16_t'(Q_MIN + longint'($urandom_range(0, 32'(gap - 1))));
		end else if (pick < 88) begin
			gap = Q_MAX - last;
			if (gap > 0)
				return q16_t'(last + 1 + longint'($urandom_range(0, 32'(gap - 1))));
		end
		return $urandom;
	endfunction

	// move one breakpoint between its neighbours
	task automatic queue_nudge(input int n);
		int     i;
		longint lo, hi;
		i = $urandom_range(0, n - 1);
		lo = (i == 0) ? Q_MIN : longint'(plan_x[i-1]) + 1;
		hi = (i == n - 1) ? Q_MAX : longint'(plan_x[i+1]) - 1;
		if (hi >= lo)
			queue_write(i, q16_t'(lo + longint'($urandom_range(0, 32'(hi - lo)))),
				random_ordinate());
	endtask

	// reset, directed requests, then random phases
	initial begin
		int                    n, shape, count, pick;
		logic [CFG_DATA_W-1:0] points;

		arst_n = 1'b0;
		sample_if.valid = 1'b0;
		sample_if.func = FUNC_WRITE;
		sample_if.point_index = '0;
		sample_if.point_x = '0;
		sample_if.point_y = '0;
		sample_if.sample_value = '0;
		result_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 26;
		recv_idle_pct = 82;

		// table spanning the whole number range
		configure(CFG_DATA_W'(2), 1'b0);
		queue_write(0, q16_t'(Q_MIN), q16_t'(Q_MAX));
		queue_write(1, q16_t'(Q_MAX), q16_t'(Q_MIN));
		queue_eval(q16_t'(Q_MIN));
		queue_eval(q16_t'(Q_MAX));
		queue_eval('0);
		queue_eval(-1);
		queue_eval(q16_t'(Q_MAX - 1));
		queue_write(31, $urandom, $urandom);

		// small table, clamping on both sides
		queue_write(0, -(1 << 16), 5 << 16);
		queue_write(1, 1 << 16, -(3 << 16));
		queue_eval(q16_t'(Q_MIN));
		queue_eval(q16_t'(Q_MAX));
		queue_eval(-(1 << 16));
		queue_eval(1 << 16);
		queue_eval(32'sh8000);

		// count below two acts as two, error mode on
		configure(CFG_DATA_W'(0), 1'b1);
		queue_eval(-(1 << 16) - 1);
		queue_eval((1 << 16) + 1);
		queue_eval(1 << 16);
		queue_eval(-12345);

		// table out of order
		configure(CFG_DATA_W'(3), 1'b1);
		queue_write(2, 3 << 16, 7 << 16);
		queue_write(1, -(4 << 16), -(2 << 16));
		queue_eval(2 << 16);
		queue_eval(3 << 16);
		queue_eval(-(2 << 16));

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph < 6)
				points = CFG_DATA_W'(count_plan[ph]);
			else if ($urandom_range(1))
				points = CFG_DATA_W'($urandom_range(2, 12));
			else
				points = CFG_DATA_W'($urandom_range(0, 63));
			configure(points, 1'(ph % 2));
			// idling pattern by thirds of the run
			case (ph * 3 / PHASES)
				0: begin
					send_idle_pct = 26;
					recv_idle_pct = 82;
				end
				1: begin
					send_idle_pct = 82;
					recv_idle_pct = 26;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			n = live_points(points);
			shape = (ph == 4 || ph == 9) ? SHAPE_SCRAMBLED : $urandom_range(0, 2);
			fill_table(n, shape);
			// mostly evaluations, a few point rewrites and stray writes
			for (count = n; count < PHASE_ITEMS; count++) begin
				pick = $urandom_range(99);
				if (pick < 8)
					queue_nudge(n);
				else if (pick < 10)
					queue_write($urandom_range(0, MAX_POINTS - 1), $urandom, random_ordinate());
				else
					queue_eval(pick_sample(n));
			end
		end

		wait_idle();
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: piecewise_linear_interpolator.f
rtl/pli_pkg.sv
rtl/pli_if.sv
rtl/pli_ctrl.sv
rtl/pli_dp.sv
rtl/piecewise_linear_interpolator.sv
sim/tb_piecewise_linear_interpolator.sv
